@@ rtl/core/deq_pkg.sv @@
// Package for the indexed double-ended queue: sizes, operation and status
// codes, request/response payload types and the per-cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Number of storage cells in the chain.
  localparam int unsigned DEPTH = 16;
  // Width of an index into the chain, and of a count that can reach DEPTH.
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Payload field widths.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_HEAD = 3'd0,
    FN_PUSH_TAIL = 3'd1,
    FN_POP_HEAD  = 3'd2,
    FN_POP_TAIL  = 3'd3,
    FN_READ      = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] read_data;
    logic                     is_empty;
    logic [FILL_W-1:0]        fill_count;
  } rsp_t;

  // Control of one storage cell.
  typedef struct packed {
    logic load;        // take the pushed word
    logic shift_right; // take the word of the neighbour nearer the head
    logic shift_left;  // take the word of the neighbour nearer the tail
  } cell_ctrl_t;

endpackage : deq_pkg

`default_nettype wire

@@ rtl/core/double_ended_queue_indexed_unit.sv @@
// Indexed double-ended queue built as a chain of DEPTH word cells, head at cell 0.
// Results: rsp_o and done_o are registered and appear in the cycle after the transfer.
// Throughput: one request per cycle; every operation is at most a single shift or load of
// the cell chain, so busy stays low. Results cannot be stalled by the receiver.
// Reset: asynchronous, active low; clears the element count and the result strobe.
// Cell contents are not reset and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_indexed_unit
  import deq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  // ---------------------------------------------------------------------------
  // Request decode. The queue is kept packed against cell 0: element k from the
  // head always lives in cell k, so a read indexes the chain directly and no
  // head pointer is needed. Pushing at the head shifts the whole chain towards
  // the tail, popping the head shifts it back, and tail operations only load the
  // first free cell or move the count.
  // ---------------------------------------------------------------------------
  logic             accept;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             full;
  logic             empty;
  logic             in_range;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // The position field may be wider or narrower than the count, so compare on
  // a common width.
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  assign in_range = (CMP_W'(req_i.position) < CMP_W'(count_q));

  cell_ctrl_t               ctrl     [DEPTH];
  logic signed [WORD_W-1:0] cell_data[DEPTH];

  logic push_head_go;
  logic push_tail_go;
  logic pop_head_go;

  assign push_head_go = accept && (req_i.func == FN_PUSH_HEAD) && !full;
  assign push_tail_go = accept && (req_i.func == FN_PUSH_TAIL) && !full;
  assign pop_head_go  = accept && (req_i.func == FN_POP_HEAD) && !empty;

  // ---------------------------------------------------------------------------
  // Cell chain. Cell 0 takes the pushed word when shifting towards the tail;
  // the last cell takes nothing useful when shifting towards the head, as it
  // becomes free in that case.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left;
    logic signed [WORD_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = req_i.value;
    end else begin : g_inner_left
      assign left = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_right
      assign right = cell_data[i+1];
    end

    assign ctrl[i].load        = push_tail_go && (count_q == CNT_W'(i));
    assign ctrl[i].shift_right = push_head_go;
    assign ctrl[i].shift_left  = pop_head_go;

    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .value_i (req_i.value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Count update and result formation. Full pushes and empty pops leave the
  // queue untouched and only report their status; unused operation codes
  // report success with nothing read.
  // ---------------------------------------------------------------------------
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic done_q;

  always_comb begin
    count_d         = count_q;
    rsp_d.status    = ST_OK;
    rsp_d.read_data = '0;
    case (req_i.func)
      FN_PUSH_HEAD, FN_PUSH_TAIL: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      FN_POP_HEAD, FN_POP_TAIL: begin
        if (empty) begin
          rsp_d.status = ST_UNDERFLOW;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      FN_READ: begin
        if (!in_range) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.read_data = cell_data[IDX_W'(req_i.position)];
        end
      end
      default: begin
      end
    endcase
    rsp_d.is_empty   = (count_d == '0);
    rsp_d.fill_count = FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // The result payload needs no reset; it is only looked at under done_o.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_follows_transfer : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o
  ) else $error("result strobe missing after a transfer");

  a_no_spurious_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o
  ) else $error("result strobe without a transfer");

  a_count_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)
  ) else $error("element count beyond the chain length");

  a_empty_flag : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.fill_count == '0))
  ) else $error("empty flag disagrees with the fill count");

  a_count_step : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> $stable(count_q)
  ) else $error("element count moved without a transfer");

endmodule : double_ended_queue_indexed_unit

`default_nettype wire

@@ rtl/core/deq_cell.sv @@
// One storage cell of the queue chain: holds a single word and can load it,
// or take the word of either neighbour. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic signed [WORD_W-1:0] value_i,
  input  wire logic signed [WORD_W-1:0] left_i,
  input  wire logic signed [WORD_W-1:0] right_i,
  output logic signed [WORD_W-1:0]      data_o
);

  logic signed [WORD_W-1:0] data_q;
  logic signed [WORD_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.shift_right) begin
      data_d = left_i;
    end else if (ctrl_i.shift_left) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule : deq_cell

`default_nettype wire
